@@ sv/cmsc_pkg.sv @@
`timescale 1ns / 1ps

package cmsc_pkg;

    // Instruction word layout
    localparam int INSTR_W = 32;
    localparam int PC_W    = 26;
    localparam int REG_W   = 32;
    localparam int RIDX_W  = 5;
    localparam int REG_COUNT = 32;

    // Data store: word addressed, power-of-two depth
    localparam int DADDR_W    = 10;
    localparam int DATA_WORDS = 1 << DADDR_W;

    // Opcodes (bits 31:26)
    localparam logic [5:0] OP_RTYPE = 6'd33;
    localparam logic [5:0] OP_JR    = 6'd41;
    localparam logic [5:0] OP_ADDI  = 6'd48;
    localparam logic [5:0] OP_LW    = 6'd18;
    localparam logic [5:0] OP_SW    = 6'd19;
    localparam logic [5:0] OP_BLT   = 6'd14;
    localparam logic [5:0] OP_JAL   = 6'd10;

    // R-type function codes (bits 5:0)
    localparam logic [5:0] FN_AND = 6'd40;
    localparam logic [5:0] FN_SUB = 6'd24;
    localparam logic [5:0] FN_SGT = 6'd10;

    localparam logic [RIDX_W-1:0] LINK_REG = 5'd31;

    // Result stream layout: tdata fields from bit 0 up
    localparam int EPC_LSB   = 0;
    localparam int NPC_LSB   = EPC_LSB + PC_W;
    localparam int WNUM_LSB  = NPC_LSB + PC_W;
    localparam int WVAL_LSB  = WNUM_LSB + RIDX_W;
    localparam int MADDR_LSB = WVAL_LSB + REG_W;
    localparam int SVAL_LSB  = MADDR_LSB + DADDR_W;
    localparam int RES_BITS  = SVAL_LSB + REG_W;
    localparam int M_TDATA_W = ((RES_BITS + 7) / 8) * 8;
    localparam int PAD_W     = M_TDATA_W - RES_BITS;

    // tuser flags
    localparam int U_REG_WRITTEN = 0;
    localparam int U_STORE_DONE  = 1;
    localparam int U_UNKNOWN     = 2;
    localparam int M_TUSER_W     = 3;

    typedef struct packed {
        logic [PC_W-1:0]    epc;
        logic [PC_W-1:0]    npc;
        logic               wr;
        logic [RIDX_W-1:0]  wnum;
        logic [REG_W-1:0]   wval;
        logic               st;
        logic [DADDR_W-1:0] maddr;
        logic [REG_W-1:0]   sval;
        logic               unk;
        logic               is_load;
    } result_t;

endpackage

@@ sv/custom_mips_subset_core.sv @@
`timescale 1ns / 1ps

// custom_mips_subset_core: single-issue core for a small MIPS-like instruction set.
// Slave stream (s_*): one 32-bit instruction word per request, fetched by the
// user at the pc most recently reported in following_pc (0 after reset).
// Master stream (m_*): one result per instruction: executed and following pc,
// register write, data store access, and flags in tuser.
// An accepted instruction moves from the execute register to the result register.
// Throughput: one instruction per cycle while the receiver takes results; an
// instruction behind a lw waits while the load's registered read data is written
// back to the register file in the cycle after the lw leaves the execute register.
// Operands come from a registered register file read with forwarding of the
// write that happens at the same edge, so dependent instructions need no gap.
// Reset clears pc, the register file (through per-register valid bits) and all
// handshake state; the data store is left undefined until written.
// When the receiver stalls, the result register holds; an empty execute register
// still takes one more instruction, then s_tready drops until m_tready returns.
module custom_mips_subset_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cmsc_pkg::INSTR_W-1:0]    s_tdata,   // [31:0] instruction_word
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [25:0] executed_pc, [51:26] following_pc, [56:52] reg_number,
    // [88:57] reg_value, [98:89] mem_address, [130:99] store_value, rest zero
    output logic [cmsc_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] reg_written, [1] store_done, [2] unknown_code
    output logic [cmsc_pkg::M_TUSER_W-1:0]  m_tuser
);
    import cmsc_pkg::*;

    // Execute register: instruction plus operands read at the same edge
    logic               d_valid_reg;
    logic [INSTR_W-1:0] ir_reg;
    logic [REG_W-1:0]   a_reg;
    logic [REG_W-1:0]   b_reg;

    // Architectural state
    logic [PC_W-1:0]      pc_reg;
    logic [REG_W-1:0]     rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [REG_W-1:0]     dmem [DATA_WORDS];

    // Result register and pending load writeback
    logic         r_valid_reg;
    result_t      r_reg;
    logic [REG_W-1:0] mem_rdata_reg;
    logic         lw_wb_reg;

    // Handshake
    logic d_load;
    logic d_advance;
    logic r_free;

    // Decode
    logic [5:0]        op;
    logic [5:0]        fn;
    logic [RIDX_W-1:0] rt;
    logic [RIDX_W-1:0] rd;
    logic [REG_W-1:0]  imm32;
    logic [PC_W-1:0]   pc_inc;
    logic [REG_W-1:0]  addr_sum;
    result_t           ex_res;

    // Register file port
    logic [RIDX_W-1:0] ra_addr;
    logic [RIDX_W-1:0] rb_addr;
    logic              wr_en;
    logic [RIDX_W-1:0] wr_addr;
    logic [REG_W-1:0]  wr_data;

    assign r_free    = !r_valid_reg || m_tready;
    // Hold the execute register during a load writeback cycle
    assign d_advance = d_valid_reg && r_free && !lw_wb_reg;
    assign s_tready  = !d_valid_reg || d_advance;
    assign d_load    = s_tvalid && s_tready;

    assign op     = ir_reg[31:26];
    assign fn     = ir_reg[5:0];
    assign rt     = ir_reg[20:16];
    assign rd     = ir_reg[15:11];
    assign imm32  = {{(REG_W-16){ir_reg[15]}}, ir_reg[15:0]};
    assign pc_inc = pc_reg + PC_W'(1);
    assign addr_sum = a_reg + imm32;

    // Execute: everything for one instruction in one pass
    always_comb
    begin
        ex_res         = '0;
        ex_res.epc     = pc_reg;
        ex_res.npc     = pc_inc;
        unique case (op)
            OP_RTYPE:
            begin
                ex_res.wr   = 1'b1;
                ex_res.wnum = rd;
                unique case (fn)
                    FN_AND:  ex_res.wval = a_reg & b_reg;
                    FN_SUB:  ex_res.wval = a_reg - b_reg;
                    FN_SGT:  ex_res.wval = {{(REG_W-1){1'b0}},
                                            ($signed(a_reg) > $signed(b_reg))};
                    default:
                    begin
                        ex_res.wr   = 1'b0;
                        ex_res.wnum = '0;
                        ex_res.unk  = 1'b1;
                    end
                endcase
            end
            OP_JR:
            begin
                ex_res.npc = a_reg[PC_W-1:0];
            end
            OP_ADDI:
            begin
                ex_res.wr   = 1'b1;
                ex_res.wnum = rt;
                ex_res.wval = addr_sum;
            end
            OP_LW:
            begin
                // value arrives registered from the data store in mem_rdata_reg
                ex_res.wr      = 1'b1;
                ex_res.wnum    = rt;
                ex_res.maddr   = addr_sum[DADDR_W-1:0];
                ex_res.is_load = 1'b1;
            end
            OP_SW:
            begin
                ex_res.st    = 1'b1;
                ex_res.maddr = addr_sum[DADDR_W-1:0];
                ex_res.sval  = b_reg;
            end
            OP_BLT:
            begin
                if ($signed(a_reg) < $signed(b_reg))
                begin
                    ex_res.npc = pc_inc + imm32[PC_W-1:0];
                end
            end
            OP_JAL:
            begin
                ex_res.wr   = 1'b1;
                ex_res.wnum = LINK_REG;
                ex_res.wval = {{(REG_W-PC_W){1'b0}}, pc_inc};
                ex_res.npc  = ir_reg[PC_W-1:0];
            end
            default:
            begin
                ex_res.unk = 1'b1;
            end
        endcase
    end

    // One write port: load writeback or an execute-stage write, never both
    assign wr_en   = lw_wb_reg || (d_advance && ex_res.wr && !ex_res.is_load);
    assign wr_addr = lw_wb_reg ? r_reg.wnum : ex_res.wnum;
    assign wr_data = lw_wb_reg ? mem_rdata_reg : ex_res.wval;

    // Read the incoming instruction's operands, or re-read while holding
    assign ra_addr = d_load ? s_tdata[25:21] : ir_reg[25:21];
    assign rb_addr = d_load ? s_tdata[20:16] : ir_reg[20:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg  <= 1'b0;
            r_valid_reg  <= 1'b0;
            lw_wb_reg    <= 1'b0;
            pc_reg       <= '0;
            rf_valid_reg <= '0;
        end
        else
        begin
            if (d_load)
            begin
                d_valid_reg <= 1'b1;
            end
            else if (d_advance)
            begin
                d_valid_reg <= 1'b0;
            end

            if (d_advance)
            begin
                r_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                r_valid_reg <= 1'b0;
            end

            lw_wb_reg <= d_advance && ex_res.is_load;

            if (d_advance)
            begin
                pc_reg <= ex_res.npc;
            end

            if (wr_en)
            begin
                rf_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Payload: register file, operand read with forwarding, result, data store
    always_ff @(posedge clk)
    begin
        if (d_load)
        begin
            ir_reg <= s_tdata;
        end

        if (wr_en)
        begin
            rf_mem[wr_addr] <= wr_data;
        end

        if (wr_en && (wr_addr == ra_addr))
        begin
            a_reg <= wr_data;
        end
        else
        begin
            a_reg <= rf_valid_reg[ra_addr] ? rf_mem[ra_addr] : '0;
        end

        if (wr_en && (wr_addr == rb_addr))
        begin
            b_reg <= wr_data;
        end
        else
        begin
            b_reg <= rf_valid_reg[rb_addr] ? rf_mem[rb_addr] : '0;
        end

        if (d_advance)
        begin
            r_reg <= ex_res;
            if (ex_res.st)
            begin
                dmem[ex_res.maddr] <= ex_res.sval;
            end
            if (ex_res.is_load)
            begin
                mem_rdata_reg <= dmem[ex_res.maddr];
            end
        end
    end

    assign m_tvalid = r_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}},
                       r_reg.sval,
                       r_reg.maddr,
                       (r_reg.is_load ? mem_rdata_reg : r_reg.wval),
                       r_reg.wnum,
                       r_reg.npc,
                       r_reg.epc};
    assign m_tuser  = {r_reg.unk, r_reg.st, r_reg.wr};

endmodule

@@ sv/cmsc_checker.sv @@
`timescale 1ns / 1ps

module cmsc_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [cmsc_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [cmsc_pkg::M_TUSER_W-1:0]  m_tuser
);
    import cmsc_pkg::*;

    logic reg_written;
    logic store_done;
    logic unknown_code;

    assign reg_written  = m_tuser[U_REG_WRITTEN];
    assign store_done   = m_tuser[U_STORE_DONE];
    assign unknown_code = m_tuser[U_UNKNOWN];

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

    // A store never also writes a register
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && store_done) |-> !reg_written)
    else $error("store reported a register write");

    // An unrecognized code has no side effect
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && unknown_code) |-> (!reg_written && !store_done))
    else $error("unknown code caused a write");

    // No register write leaves the register fields at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !reg_written) |->
        ((m_tdata[WNUM_LSB +: RIDX_W] == '0) && (m_tdata[WVAL_LSB +: REG_W] == '0)))
    else $error("register fields set without a write");

endmodule

bind custom_mips_subset_core cmsc_checker u_cmsc_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import cmsc_pkg::*;

    // One retired instruction as seen on the result stream
    typedef struct packed {
        logic [PC_W-1:0]    epc;
        logic [PC_W-1:0]    npc;
        logic               wr;
        logic [RIDX_W-1:0]  wnum;
        logic [REG_W-1:0]   wval;
        logic               st;
        logic [DADDR_W-1:0] maddr;
        logic [REG_W-1:0]   sval;
        logic               unk;
    } retire_t;

    typedef struct {
        logic [INSTR_W-1:0] word;
        int                 typed;
        retire_t            res;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [INSTR_W-1:0]    s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    // Architectural state of the core, advanced in program order
    logic [PC_W-1:0]  pc_model;
    logic [REG_W-1:0] reg_bank [REG_COUNT];
    logic [REG_W-1:0] data_words [DATA_WORDS];
    bit               word_stored [DATA_WORDS];
    int               stored_addrs [$];

    retire_t   retire_queue [$];
    stim_row_t directed_rows [$];
    int        mismatch_count = 0;
    int        results_seen   = 0;
    int        send_idle_pct  = 12;
    int        recv_idle_pct  = 50;

    custom_mips_subset_core uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #2_000_000;
        $display("custom_mips_subset_core: mismatch");
        $finish;
    end

    function automatic logic [INSTR_W-1:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                                 input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [INSTR_W-1:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                                 input logic [4:0] rd, input logic [5:0] fn);
        return {OP_RTYPE, rs, rt, rd, 5'd0, fn};
    endfunction

    function automatic logic [INSTR_W-1:0] enc_j(input logic [5:0] op, input logic [25:0] target);
        return {op, target};
    endfunction

    function automatic retire_t mk_retire(input logic [PC_W-1:0] epc, input logic [PC_W-1:0] npc,
                                          input logic wr, input logic [RIDX_W-1:0] wnum,
                                          input logic [REG_W-1:0] wval, input logic unk);
        retire_t r;
        r       = '0;
        r.epc   = epc;
        r.npc   = npc;
        r.wr    = wr;
        r.wnum  = wnum;
        r.wval  = wval;
        r.unk   = unk;
        return r;
    endfunction

    function automatic string fmt_retire(input retire_t r);
        return $sformatf("epc=%h npc=%h wr=%b rd=%0d val=%h st=%b addr=%0d sval=%h unk=%b",
                         r.epc, r.npc, r.wr, r.wnum, r.wval, r.st, r.maddr, r.sval, r.unk);
    endfunction

    // Execute one instruction against the local state and return what it retires
    task automatic execute_instr(input logic [INSTR_W-1:0] w, output retire_t r);
        logic [5:0]       op;
        logic [5:0]       fn;
        logic [4:0]       rs;
        logic [4:0]       rt;
        logic [4:0]       rd;
        logic [REG_W-1:0] imm;
        logic [REG_W-1:0] a;
        logic [REG_W-1:0] b;
        logic [REG_W-1:0] sum;
        logic [PC_W-1:0]  nxt;
        op  = w[31:26];
        rs  = w[25:21];
        rt  = w[20:16];
        rd  = w[15:11];
        fn  = w[5:0];
        imm = {{16{w[15]}}, w[15:0]};
        a   = reg_bank[rs];
        b   = reg_bank[rt];
        sum = a + imm;
        nxt = pc_model + 26'd1;
        r     = '0;
        r.epc = pc_model;
        case (op)
            OP_RTYPE:
            begin
                r.wr   = 1'b1;
                r.wnum = rd;
                case (fn)
                    FN_AND: r.wval = a & b;
                    FN_SUB: r.wval = a - b;
                    FN_SGT: r.wval = ($signed(a) > $signed(b)) ? 32'd1 : 32'd0;
                    default:
                    begin
                        r.wr   = 1'b0;
                        r.wnum = '0;
                        r.unk  = 1'b1;
                    end
                endcase
            end
            OP_JR:   nxt = a[PC_W-1:0];
            OP_ADDI:
            begin
                r.wr   = 1'b1;
                r.wnum = rt;
                r.wval = sum;
            end
            OP_LW:
            begin
                r.maddr = sum[DADDR_W-1:0];
                r.wr    = 1'b1;
                r.wnum  = rt;
                r.wval  = data_words[r.maddr];
            end
            OP_SW:
            begin
                r.maddr = sum[DADDR_W-1:0];
                r.st    = 1'b1;
                r.sval  = b;
                data_words[r.maddr] = b;
                if (!word_stored[r.maddr])
                begin
                    word_stored[r.maddr] = 1'b1;
                    stored_addrs.push_back(int'(r.maddr));
                end
            end
            OP_BLT:
            begin
                if ($signed(a) < $signed(b))
                    nxt = pc_model + 26'd1 + imm[PC_W-1:0];
            end
            OP_JAL:
            begin
                r.wr   = 1'b1;
                r.wnum = LINK_REG;
                r.wval = {6'd0, pc_model + 26'd1};
                nxt    = w[PC_W-1:0];
            end
            default: r.unk = 1'b1;
        endcase
        if (r.wr)
            reg_bank[r.wnum] = r.wval;
        pc_model = nxt;
        r.npc    = nxt;
    endtask

    // Mostly well-formed instructions, some unknown codes and raw noise
    task automatic make_instr(output logic [INSTR_W-1:0] w);
        int         sel;
        logic [4:0] rs;
        logic [4:0] rt;
        logic [4:0] rd;
        logic [5:0] fn;
        logic [9:0] tgt;
        sel = $urandom_range(99);
        rs  = 5'($urandom_range(31));
        rt  = 5'($urandom_range(31));
        rd  = 5'($urandom_range(31));
        case ($urandom_range(2))
            0:       fn = FN_AND;
            1:       fn = FN_SUB;
            default: fn = FN_SGT;
        endcase
        if (sel < 20)
            w = enc_i(OP_ADDI, rs, rt, 16'($urandom));
        else if (sel < 42)
            w = enc_r(rs, rt, rd, fn);
        else if (sel < 54)
            w = enc_i(OP_SW, rs, rt, 16'($urandom));
        else if (sel < 66)
            w = enc_i(OP_LW, rs, rt, 16'($urandom));
        else if (sel < 74)
            w = enc_i(OP_BLT, rs, rt, 16'($urandom));
        else if (sel < 78)
            w = enc_j(OP_JAL, 26'($urandom));
        else if (sel < 82)
            w = enc_j(OP_JR, {rs, 21'($urandom)});
        else if (sel < 88)
            w = {OP_RTYPE, 26'($urandom)};
        else
            w = $urandom;
        // steer loads onto words that hold data
        if (w[31:26] == OP_LW)
        begin
            if (stored_addrs.size() == 0)
                w[31:26] = OP_SW;
            else
            begin
                tgt     = 10'(stored_addrs[$urandom_range(stored_addrs.size() - 1)]);
                w[9:0]  = tgt - reg_bank[w[25:21]][9:0];
            end
        end
    endtask

    // Hold the request until the core takes it; return on the accepting edge
    task automatic send_instr(input logic [INSTR_W-1:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
    endtask

    task automatic add_row(input logic [INSTR_W-1:0] w, input int typed, input retire_t res);
        stim_row_t row;
        row.word  = w;
        row.typed = typed;
        row.res   = res;
        directed_rows.push_back(row);
    endtask

    always @(posedge clk)
        m_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    // Compare each result against the oldest outstanding prediction
    always @(negedge clk)
    begin : result_check
        retire_t got;
        retire_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.epc   = m_tdata[EPC_LSB +: PC_W];
            got.npc   = m_tdata[NPC_LSB +: PC_W];
            got.wnum  = m_tdata[WNUM_LSB +: RIDX_W];
            got.wval  = m_tdata[WVAL_LSB +: REG_W];
            got.maddr = m_tdata[MADDR_LSB +: DADDR_W];
            got.sval  = m_tdata[SVAL_LSB +: REG_W];
            got.wr    = m_tuser[U_REG_WRITTEN];
            got.st    = m_tuser[U_STORE_DONE];
            got.unk   = m_tuser[U_UNKNOWN];
            if (retire_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d unexpected: %s", results_seen, fmt_retire(got));
            end
            else
            begin
                want = retire_queue.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("result %0d expected: %s", results_seen, fmt_retire(want));
                        $display("result %0d actual:   %s", results_seen, fmt_retire(got));
                    end
                end
            end
            results_seen++;
        end
    end

    initial
    begin : stimulus
        retire_t            pred;
        retire_t            none;
        logic [INSTR_W-1:0] w;
        int                 n_random;
        none     = '0;
        n_random = 1000;
        pc_model = '0;
        for (int i = 0; i < REG_COUNT; i++)
            reg_bank[i] = '0;
        for (int i = 0; i < DATA_WORDS; i++)
        begin
            data_words[i]  = '0;
            word_stored[i] = 1'b0;
        end

        // extremes of the immediate, unknown opcodes and functions
        add_row(enc_i(OP_ADDI, 5'd0, 5'd1, 16'h7FFF), 1,
                mk_retire(26'd0, 26'd1, 1'b1, 5'd1, 32'h0000_7FFF, 1'b0));
        add_row(enc_i(OP_ADDI, 5'd0, 5'd2, 16'h8000), 1,
                mk_retire(26'd1, 26'd2, 1'b1, 5'd2, 32'hFFFF_8000, 1'b0));
        add_row(32'hFFFF_FFFF, 1, mk_retire(26'd2, 26'd3, 1'b0, 5'd0, 32'd0, 1'b1));
        add_row(32'h0000_0000, 1, mk_retire(26'd3, 26'd4, 1'b0, 5'd0, 32'd0, 1'b1));
        add_row(enc_r(5'd1, 5'd2, 5'd3, 6'h3F), 1,
                mk_retire(26'd4, 26'd5, 1'b0, 5'd0, 32'd0, 1'b1));
        // arithmetic and compares on mixed signs
        add_row(enc_i(OP_ADDI, 5'd2, 5'd3, 16'h8000), 0, none);
        add_row(enc_r(5'd1, 5'd2, 5'd4, FN_AND), 0, none);
        add_row(enc_r(5'd1, 5'd2, 5'd5, FN_SUB), 0, none);
        add_row(enc_r(5'd1, 5'd2, 5'd6, FN_SGT), 0, none);
        add_row(enc_r(5'd2, 5'd1, 5'd6, FN_SGT), 0, none);
        // stores and loads at both ends of the data store, address wrap
        add_row(enc_i(OP_SW, 5'd0, 5'd1, 16'h03FF), 0, none);
        add_row(enc_i(OP_SW, 5'd0, 5'd2, 16'hFC00), 0, none);
        add_row(enc_i(OP_LW, 5'd1, 5'd9, 16'h0400), 0, none);
        add_row(enc_i(OP_LW, 5'd0, 5'd10, 16'h0000), 0, none);
        // branches taken backward and forward, not taken, jumps and pc wrap
        add_row(enc_i(OP_BLT, 5'd2, 5'd1, 16'hFFFF), 0, none);
        add_row(enc_i(OP_BLT, 5'd1, 5'd2, 16'h0005), 0, none);
        add_row(enc_i(OP_BLT, 5'd2, 5'd1, 16'h7FFF), 0, none);
        add_row(enc_j(OP_JAL, 26'h3FF_FFFF), 0, none);
        add_row(enc_i(OP_ADDI, 5'd0, 5'd0, 16'h0001), 0, none);
        add_row(enc_j(OP_JR, {5'd2, 21'h1F_FFFF}), 0, none);
        add_row(enc_j(OP_JR, {5'd31, 21'h00_0000}), 0, none);
        add_row(enc_j(OP_JAL, 26'h000_0000), 0, none);
        add_row(enc_r(5'd31, 5'd31, 5'd0, FN_AND), 0, none);
        add_row(enc_i(OP_BLT, 5'd1, 5'd1, 16'h0010), 0, none);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            execute_instr(directed_rows[i].word, pred);
            retire_queue.push_back(directed_rows[i].typed ? directed_rows[i].res : pred);
            send_instr(directed_rows[i].word);
        end

        for (int i = 0; i < n_random; i++)
        begin
            // swap idle ratios after a third, drop idling for the last third
            if (i == n_random / 3)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 12;
            end
            else if (i == 2 * n_random / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            make_instr(w);
            execute_instr(w, pred);
            retire_queue.push_back(pred);
            send_instr(w);
        end
        s_tvalid <= 1'b0;

        while (retire_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("custom_mips_subset_core: match");
        else
            $display("custom_mips_subset_core: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/cmsc_pkg.sv
sv/custom_mips_subset_core.sv
sv/cmsc_checker.sv
tb/sv/tb_top.sv
